[design/smps_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smps_pkg
// shared types and constants of the serial mouse packet serializer
// ---------------------------------------------------------------------------
package smps_pkg;

  localparam int unsigned TimeW        = 48;
  localparam int unsigned PeriodW      = 16;
  localparam int unsigned DeltaW       = 8;
  localparam int unsigned ByteW        = 7;
  localparam int unsigned NumBytes     = 3;
  localparam int unsigned QueueDepth   = 2;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd2812;

  // input action codes
  typedef enum logic [2:0] {
    ACT_BTN_DOWN = 3'd0,
    ACT_BTN_UP   = 3'd1,
    ACT_MOTION   = 3'd2,
    ACT_READ     = 3'd3,
    ACT_SYNC     = 3'd4
  } action_e;

  // button codes
  typedef enum logic [1:0] {
    BTN_LEFT   = 2'd0,
    BTN_MIDDLE = 2'd1,
    BTN_RIGHT  = 2'd2,
    BTN_SPARE  = 2'd3
  } button_e;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_EVENT = 2'd1,
    OP_READ  = 2'd2,
    OP_SYNC  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e                 kind;
    logic                     set_left;
    logic                     set_right;
    logic                     down;
    logic                     stage_req;
    logic [DeltaW-1:0]        dx;
    logic [DeltaW-1:0]        dy;
    logic [TimeW-1:0]         now;
    logic [TimeW-1:0]         next_time;
  } op_t;

endpackage

[design/smps_ifs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smps interfaces
// valid/ready channels for events, results and the bit period register
// ---------------------------------------------------------------------------
interface smps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            action;
  logic [1:0]                            button_id;
  logic signed [smps_pkg::DeltaW-1:0]    delta_x;
  logic signed [smps_pkg::DeltaW-1:0]    delta_y;
  logic                                  host_armed;
  logic [smps_pkg::TimeW-1:0]            time_now;

  modport source (output valid, action, button_id, delta_x, delta_y, host_armed,
                  time_now, input ready);
  modport sink   (input valid, action, button_id, delta_x, delta_y, host_armed,
                  time_now, output ready);
endinterface

interface smps_out_if;
  logic valid;
  logic ready;
  logic data_line;
  logic clock_line;
  logic busy_res;

  modport source (output valid, data_line, clock_line, busy_res, input ready);
  modport sink   (input valid, data_line, clock_line, busy_res, output ready);
endinterface

interface smps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smps_pkg::PeriodW-1:0]  bit_period;

  modport source (output valid, bit_period, input ready);
  modport sink   (input valid, bit_period, output ready);
endinterface

[design/smps_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smps_front
// holds the bit period, classifies incoming beats into operations
// ---------------------------------------------------------------------------
module smps_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  smps_in_if.sink        in_i,
  smps_cfg_if.sink       cfg_i,
  input  logic           q_ready_i,
  output logic           q_valid_o,
  output smps_pkg::op_t  q_op_o
);

  logic [smps_pkg::PeriodW-1:0] bit_period_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= smps_pkg::PeriodReset;
    end else if (cfg_i.valid) begin
      bit_period_q <= cfg_i.bit_period;
    end
  end

  assign in_i.ready = q_ready_i;
  assign q_valid_o  = in_i.valid;

  always_comb begin
    q_op_o           = '0;
    q_op_o.kind      = smps_pkg::OP_NONE;
    q_op_o.now       = in_i.time_now;
    q_op_o.next_time = in_i.time_now +
                       {{(smps_pkg::TimeW-smps_pkg::PeriodW){1'b0}}, bit_period_q};
    q_op_o.down      = (in_i.action == smps_pkg::ACT_BTN_DOWN);
    case (in_i.action)
      smps_pkg::ACT_BTN_DOWN, smps_pkg::ACT_BTN_UP: begin
        // middle button is dropped outright, deltas forced to zero
        if (in_i.button_id != smps_pkg::BTN_MIDDLE) begin
          q_op_o.kind      = smps_pkg::OP_EVENT;
          q_op_o.set_left  = (in_i.button_id == smps_pkg::BTN_LEFT);
          q_op_o.set_right = (in_i.button_id == smps_pkg::BTN_RIGHT);
          q_op_o.stage_req = in_i.host_armed;
        end
      end
      smps_pkg::ACT_MOTION: begin
        q_op_o.kind      = smps_pkg::OP_EVENT;
        q_op_o.stage_req = in_i.host_armed;
        q_op_o.dx        = in_i.delta_x;
        q_op_o.dy        = in_i.delta_y;
      end
      smps_pkg::ACT_READ: q_op_o.kind = smps_pkg::OP_READ;
      smps_pkg::ACT_SYNC: q_op_o.kind = smps_pkg::OP_SYNC;
      default:            q_op_o.kind = smps_pkg::OP_NONE;
    endcase
  end

endmodule

[design/smps_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smps_queue
// small fifo of classified operations between front and back
// ---------------------------------------------------------------------------
module smps_queue #(
  parameter int unsigned DEPTH = smps_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  smps_pkg::op_t  push_op_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output smps_pkg::op_t  pop_op_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  smps_pkg::op_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[design/smps_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smps_back
// button state, packet staging, bit sender and the result register
// ---------------------------------------------------------------------------
module smps_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  output logic           op_ready_o,
  input  smps_pkg::op_t  op_i,
  smps_out_if.source     res_o
);

  localparam int unsigned ByteW = smps_pkg::ByteW;
  localparam logic [1:0]  LastByte = 2'(smps_pkg::NumBytes);
  localparam logic [3:0]  StopBit  = 4'd8;

  logic [ByteW-1:0] staged_q  [smps_pkg::NumBytes];
  logic [ByteW-1:0] sending_q [smps_pkg::NumBytes];

  logic                       staged_flag_q, staged_flag_d;
  logic                       sending_flag_q, sending_flag_d;
  logic [1:0]                 byte_idx_q, byte_idx_d;
  logic [3:0]                 bit_idx_q, bit_idx_d;
  logic [smps_pkg::TimeW-1:0] next_time_q, next_time_d;
  logic                       data_q, data_d;
  logic                       clock_q, clock_d;
  logic                       left_q, left_d;
  logic                       right_q, right_d;
  logic                       out_valid_q;

  logic                       take, stage, load;
  logic [ByteW-1:0]           cur_byte;
  logic [2:0]                 bit_sel;

  assign op_ready_o  = !out_valid_q || res_o.ready;
  assign take        = op_valid_i && op_ready_o;
  assign res_o.valid = out_valid_q;
  assign res_o.data_line  = data_q;
  assign res_o.clock_line = clock_q;
  assign res_o.busy_res   = staged_flag_q || sending_flag_q;

  assign cur_byte = (byte_idx_q < LastByte) ? sending_q[byte_idx_q] : '0;
  assign bit_sel  = bit_idx_q[2:0] - 3'd1;

  always_comb begin
    staged_flag_d  = staged_flag_q;
    sending_flag_d = sending_flag_q;
    byte_idx_d     = byte_idx_q;
    bit_idx_d      = bit_idx_q;
    next_time_d    = next_time_q;
    data_d         = data_q;
    clock_d        = clock_q;
    left_d         = left_q;
    right_d        = right_q;
    stage          = 1'b0;
    load           = 1'b0;
    case (op_i.kind)
      smps_pkg::OP_EVENT: begin
        if (op_i.set_left)  left_d  = op_i.down;
        if (op_i.set_right) right_d = op_i.down;
        if (op_i.stage_req && !staged_flag_q && !sending_flag_q) begin
          stage         = 1'b1;
          staged_flag_d = 1'b1;
        end
      end
      smps_pkg::OP_READ: begin
        // a staged packet moves into the sender first
        if (staged_flag_q && !sending_flag_q) begin
          load           = 1'b1;
          staged_flag_d  = 1'b0;
          sending_flag_d = 1'b1;
          byte_idx_d     = '0;
          bit_idx_d      = '0;
          next_time_d    = op_i.now;
          data_d         = 1'b0;
          clock_d        = 1'b0;
        end
        if (!sending_flag_d) begin
          data_d  = 1'b0;
          clock_d = 1'b0;
        end else if (op_i.now >= next_time_d) begin
          next_time_d = op_i.next_time;
          if (bit_idx_d == '0) begin
            if (byte_idx_d >= LastByte) begin
              sending_flag_d = 1'b0;
            end else begin
              bit_idx_d = 4'd1;
              data_d    = 1'b1;
              clock_d   = 1'b1;
            end
          end else if (bit_idx_d >= StopBit) begin
            bit_idx_d  = '0;
            byte_idx_d = byte_idx_q + 2'd1;
            data_d     = 1'b0;
            clock_d    = 1'b1;
          end else begin
            // data bits go out inverted, lsb first
            data_d    = !cur_byte[bit_sel];
            clock_d   = 1'b1;
            bit_idx_d = bit_idx_q + 4'd1;
          end
        end
      end
      smps_pkg::OP_SYNC: clock_d = 1'b0;
      default: ;
    endcase
  end

  // packet payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take && stage) begin
      staged_q[0] <= {1'b1, left_d, right_d, op_i.dy[7:6], op_i.dx[7:6]};
      staged_q[1] <= {1'b0, op_i.dx[5:0]};
      staged_q[2] <= {1'b0, op_i.dy[5:0]};
    end
    if (take && load) begin
      sending_q <= staged_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_flag_q  <= 1'b0;
      sending_flag_q <= 1'b0;
      byte_idx_q     <= '0;
      bit_idx_q      <= '0;
      next_time_q    <= '0;
      data_q         <= 1'b0;
      clock_q        <= 1'b0;
      left_q         <= 1'b0;
      right_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (take) begin
        staged_flag_q  <= staged_flag_d;
        sending_flag_q <= sending_flag_d;
        byte_idx_q     <= byte_idx_d;
        bit_idx_q      <= bit_idx_d;
        next_time_q    <= next_time_d;
        data_q         <= data_d;
        clock_q        <= clock_d;
        left_q         <= left_d;
        right_q        <= right_d;
        out_valid_q    <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[design/serial_mouse_packet_serializer.sv]
`timescale 1ns / 1ps
// result path: each accepted event beat is written into the queue at the accepting
// edge; the back stage then takes it from the queue, updates state and loads the
// result register, which drives the result beat
// throughput: one event beat per cycle while the result output is not stalled
// reset: asynchronous, active low; all control state and flags clear at once,
// bit period returns to 2812, packet byte stores stay undefined until written
// ---------------------------------------------------------------------------
// serial_mouse_packet_serializer
// two-button serial mouse: stages three-byte packets and shifts them out
// ---------------------------------------------------------------------------
module serial_mouse_packet_serializer #(
  parameter int unsigned QUEUE_DEPTH = smps_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smps_in_if.sink    in_i,
  smps_cfg_if.sink   cfg_i,
  smps_out_if.source res_o
);

  // front to queue
  logic          fq_valid, fq_ready;
  smps_pkg::op_t fq_op;

  // queue to back
  logic          qb_valid, qb_ready;
  smps_pkg::op_t qb_op;

  // front: bit period register, decode of each event beat, and the
  // precomputed next bit time so the back stage only compares
  smps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (fq_ready),
    .q_valid_o (fq_valid),
    .q_op_o    (fq_op)
  );

  // short fifo so a stalled result does not stall event intake at once
  smps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_op_o     (qb_op)
  );

  // back: button state, staging, serial sender; result register on output
  smps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (qb_valid),
    .op_ready_o (qb_ready),
    .op_i       (qb_op),
    .res_o      (res_o)
  );

endmodule
